>>> src/lru_page_replacement_core_assert.svh
// ----------------------------------------------------------------------------
// LRU page replacement core - assertion macros
// Immediate-consequence and next-cycle property forms, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define LRU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lru_pr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement - shared package
// Sizes, configuration register indexes, reset values, sequencer states and
// the layout of one frame table entry.
// ----------------------------------------------------------------------------
package lru_pr_pkg;

    localparam int MAX_FRAMES  = 16;
    localparam int FRAME_IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W       = $clog2(MAX_FRAMES + 1);

    localparam int DATA_W      = 32;
    localparam int FRAME_W     = 4;
    localparam int FIU_W       = 5;
    localparam int CFG_IDX_W   = 1;

    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'd1;

    localparam logic [DATA_W-1:0] PAGE_SIZE_RST     = 32'd4096;
    localparam logic [FIU_W-1:0]  FRAMES_IN_USE_RST = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] page;
        logic [DATA_W-1:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> src/lru_pr_ram.sv
// ----------------------------------------------------------------------------
// LRU page replacement - frame table RAM
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. No reset on the contents.
// ----------------------------------------------------------------------------
module lru_pr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/lru_pr_div.sv
// ----------------------------------------------------------------------------
// LRU page replacement - page number divider
// Restoring unsigned divider, one quotient bit per cycle. done pulses for
// one cycle once the quotient is valid; the quotient holds until next start.
// ----------------------------------------------------------------------------
module lru_pr_div
    import lru_pr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DATA_W:0]      shifted;
    logic [DATA_W+1:0]    diff;
    logic                 ge;

    // shift in the next dividend bit and trial-subtract the divisor
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DATA_W-1]};
        diff     = {1'b0, shifted} - {2'b00, dvs_reg};
        ge       = !diff[DATA_W+1];
        rem_next = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        quo_next = {quo_reg[DATA_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // pulse on the last step only
            done_reg <= busy_reg && !start && (cnt_reg == DIV_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> src/lru_page_replacement_core.sv
// ----------------------------------------------------------------------------
// LRU page replacement core - top level
// Each address passes through the 32-step page divider and then the
// one-entry-per-cycle frame table scan before its result is written back.
// A new address is taken only in idle, once the previous result is loaded.
// Reset: frames empty, counters zero, page size 4096, 16 frames; no sweep.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_core_assert.svh"

module lru_page_replacement_core
    import lru_pr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [DATA_W-1:0]    address,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic [FRAME_W-1:0]   frame,
    output logic                 evicted_valid,
    output logic [DATA_W-1:0]    evicted_page,
    output logic [DATA_W-1:0]    fault_total,
    output logic [DATA_W-1:0]    reference_total
);

    state_t state_reg, state_next;

    logic [DATA_W-1:0]      page_size_reg;
    logic [FIU_W-1:0]       frames_reg;
    logic [MAX_FRAMES-1:0]  frame_valid_reg;
    // the access clock always equals the reference count, so one register serves
    logic [DATA_W-1:0]      ref_count_reg;
    logic [DATA_W-1:0]      fault_count_reg;

    logic [DATA_W-1:0]      page_reg;
    logic [CNT_W-1:0]       issue_reg;
    logic                   chk_valid_reg;
    logic [FRAME_IDX_W-1:0] chk_idx_reg;
    logic                   hit_found_reg;
    logic [FRAME_IDX_W-1:0] hit_slot_reg;
    logic [DATA_W-1:0]      best_stamp_reg;
    logic [FRAME_IDX_W-1:0] best_slot_reg;
    logic [DATA_W-1:0]      best_page_reg;

    logic                   res_hit_reg;
    logic [FRAME_W-1:0]     res_frame_reg;
    logic                   res_evict_reg;
    logic [DATA_W-1:0]      res_evpage_reg;
    logic [DATA_W-1:0]      res_fault_reg;
    logic [DATA_W-1:0]      res_ref_reg;

    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [FRAME_W-1:0]     out_frame_reg;
    logic                   out_evict_reg;
    logic [DATA_W-1:0]      out_evpage_reg;
    logic [DATA_W-1:0]      out_fault_reg;
    logic [DATA_W-1:0]      out_ref_reg;

    logic [CNT_W-1:0]       n_act;
    logic                   in_accept;
    logic                   div_start;
    logic                   div_done;
    logic [DATA_W-1:0]      div_quotient;
    logic [DATA_W-1:0]      divisor;

    logic                   mem_re;
    logic [FRAME_IDX_W-1:0] mem_raddr;
    logic                   mem_we;
    entry_t                 mem_wdata;
    entry_t                 rd_entry;
    logic [ENTRY_W-1:0]     rd_bits;

    logic                   scan_more;
    logic                   scan_end;
    logic                   cur_match;
    logic                   empty_found;
    logic [FRAME_IDX_W-1:0] empty_slot;
    logic                   do_evict;
    logic [FRAME_IDX_W-1:0] wr_slot;
    logic [DATA_W-1:0]      wr_slot_wide;
    logic                   out_load;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg <= PAGE_SIZE_RST;
            frames_reg    <= FRAMES_IN_USE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PAGE_SIZE:     page_size_reg <= cfg_data;
                CFG_FRAMES_IN_USE: frames_reg    <= cfg_data[FIU_W-1:0];
            endcase
        end
    end

    // clamp frames in use into 1..MAX_FRAMES
    always_comb
    begin
        if (frames_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (32'(frames_reg) > 32'(MAX_FRAMES))
        begin
            n_act = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            n_act = CNT_W'(frames_reg);
        end
    end

    // ------------------------------------------------------------------
    // divider and frame table
    // ------------------------------------------------------------------
    assign divisor = (page_size_reg == '0) ? DATA_W'(1) : page_size_reg;

    lru_pr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (address),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    lru_pr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_FRAMES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_slot),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_bits)
    );

    assign rd_entry = entry_t'(rd_bits);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign in_accept = in_valid && !in_stall;
    assign scan_more = (issue_reg < n_act);
    assign scan_end  = !scan_more && !chk_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        div_start = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        out_load  = 1'b0;
        mem_raddr = issue_reg[FRAME_IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                div_start = in_valid;
            end
            ST_DIVIDE:
            begin
            end
            ST_SCAN:
            begin
                mem_re = scan_more;
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // scan: one entry read per cycle, checked the cycle after
    // ------------------------------------------------------------------
    assign cur_match = frame_valid_reg[chk_idx_reg] && (rd_entry.page == page_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            hit_found_reg <= 1'b0;
        end
        else if (state_reg == ST_DIVIDE)
        begin
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            hit_found_reg <= 1'b0;
        end
        else if (state_reg == ST_SCAN)
        begin
            chk_valid_reg <= scan_more;
            if (scan_more)
            begin
                issue_reg <= issue_reg + 1'b1;
            end
            if (chk_valid_reg && cur_match && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIVIDE && div_done)
        begin
            page_reg <= div_quotient;
        end
        if (state_reg == ST_SCAN)
        begin
            chk_idx_reg <= issue_reg[FRAME_IDX_W-1:0];
            if (chk_valid_reg)
            begin
                if (cur_match && !hit_found_reg)
                begin
                    hit_slot_reg <= chk_idx_reg;
                end
                // strict less-than keeps the lowest index on equal stamps
                if (chk_idx_reg == '0 || rd_entry.stamp < best_stamp_reg)
                begin
                    best_stamp_reg <= rd_entry.stamp;
                    best_slot_reg  <= chk_idx_reg;
                    best_page_reg  <= rd_entry.page;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // slot choice and write-back
    // ------------------------------------------------------------------
    always_comb
    begin
        empty_found = 1'b0;
        empty_slot  = '0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (!empty_found && !frame_valid_reg[i] && (32'(i) < 32'(n_act)))
            begin
                empty_found = 1'b1;
                empty_slot  = FRAME_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        do_evict = !hit_found_reg && !empty_found;
        if (hit_found_reg)
        begin
            wr_slot = hit_slot_reg;
        end
        else if (empty_found)
        begin
            wr_slot = empty_slot;
        end
        else
        begin
            wr_slot = best_slot_reg;
        end
        wr_slot_wide    = DATA_W'(wr_slot);
        mem_wdata.page  = page_reg;
        mem_wdata.stamp = ref_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= '0;
            ref_count_reg   <= '0;
            fault_count_reg <= '0;
        end
        else if (state_reg == ST_WRITE)
        begin
            frame_valid_reg[wr_slot] <= 1'b1;
            ref_count_reg            <= ref_count_reg + 1'b1;
            if (!hit_found_reg)
            begin
                fault_count_reg <= fault_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
        begin
            res_hit_reg    <= hit_found_reg;
            res_frame_reg  <= wr_slot_wide[FRAME_W-1:0];
            res_evict_reg  <= do_evict;
            res_evpage_reg <= do_evict ? best_page_reg : '0;
            res_fault_reg  <= fault_count_reg + DATA_W'(!hit_found_reg);
            res_ref_reg    <= ref_count_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // output register: holds a beat while the next item is taken in
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hit_reg    <= res_hit_reg;
            out_frame_reg  <= res_frame_reg;
            out_evict_reg  <= res_evict_reg;
            out_evpage_reg <= res_evpage_reg;
            out_fault_reg  <= res_fault_reg;
            out_ref_reg    <= res_ref_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign hit             = out_hit_reg;
    assign frame           = out_frame_reg;
    assign evicted_valid   = out_evict_reg;
    assign evicted_page    = out_evpage_reg;
    assign fault_total     = out_fault_reg;
    assign reference_total = out_ref_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `LRU_ASSERT_SAME(a_div_done_in_divide, div_done, state_reg == ST_DIVIDE, "divider finished outside the divide phase")
    `LRU_ASSERT_SAME(a_scan_bounded, state_reg == ST_SCAN, issue_reg <= n_act, "scan ran past the frames in use")
    `LRU_ASSERT_NEXT(a_slot_valid_after_write, state_reg == ST_WRITE, frame_valid_reg[$past(wr_slot)], "written frame not marked valid")
    `LRU_ASSERT_SAME(a_hit_never_evicts, out_valid_reg && out_hit_reg, !out_evict_reg && (out_evpage_reg == '0), "hit beat reports an eviction")

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement core - self-checking testbench
// Feeds address beats through a random-gap driver, collects lookup results
// through a randomly stalling monitor and checks every field against a
// scoreboard kept by an in-bench LRU frame table. Page size and frames in use
// are reprogrammed between drained phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
    import lru_pr_pkg::*;

    localparam int unsigned IDLE_LIMIT  = 5000;
    localparam int unsigned TAIL_CYCLES = 80;

    typedef struct packed {
        logic                hit;
        logic [FRAME_W-1:0]  frame;
        logic                evicted_valid;
        logic [DATA_W-1:0]   evicted_page;
        logic [DATA_W-1:0]   fault_total;
        logic [DATA_W-1:0]   reference_total;
    } lookup_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PAGE_SIZE;
    logic [DATA_W-1:0]    cfg_data = '0;

    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [DATA_W-1:0]    address = '0;

    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 hit;
    logic [FRAME_W-1:0]   frame;
    logic                 evicted_valid;
    logic [DATA_W-1:0]    evicted_page;
    logic [DATA_W-1:0]    fault_total;
    logic [DATA_W-1:0]    reference_total;

    lru_page_replacement_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .address         (address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hit             (hit),
        .frame           (frame),
        .evicted_valid   (evicted_valid),
        .evicted_page    (evicted_page),
        .fault_total     (fault_total),
        .reference_total (reference_total)
    );

    // Mirror of the block's registers and frame table
    logic [DATA_W-1:0] page_size_now = PAGE_SIZE_RST;
    logic [FIU_W-1:0]  frames_now    = FRAMES_IN_USE_RST;
    logic [DATA_W-1:0] page_of_frame  [MAX_FRAMES] = '{default: '0};
    logic [DATA_W-1:0] stamp_of_frame [MAX_FRAMES] = '{default: '0};
    bit                frame_held     [MAX_FRAMES] = '{default: 1'b0};
    logic [DATA_W-1:0] access_clock_now = '0;
    logic [DATA_W-1:0] faults_now       = '0;
    logic [DATA_W-1:0] references_now   = '0;

    logic [DATA_W-1:0] address_backlog [$];
    lookup_t           expected_lookups [$];

    bit          quiet = 1'b0;
    int unsigned accesses_loaded = 0;
    int unsigned results_seen    = 0;
    int unsigned mismatch_count  = 0;
    int unsigned hit_tally       = 0;
    int unsigned eviction_tally  = 0;
    int unsigned settings_run    = 0;
    int unsigned send_gap        = 0;
    int unsigned stall_left      = 0;
    int unsigned idle_cycles     = 0;

    function automatic int unsigned active_span();
        if (frames_now == 0)
            return 1;
        if (frames_now > MAX_FRAMES)
            return MAX_FRAMES;
        return frames_now;
    endfunction

    // Mostly short pauses, now and then a long one
    function automatic int unsigned pause_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic string show_lookup(input lookup_t r);
        return $sformatf("hit=%0d frame=%0d evicted_valid=%0d evicted_page=%h faults=%0d refs=%0d",
                         r.hit, r.frame, r.evicted_valid, r.evicted_page,
                         r.fault_total, r.reference_total);
    endfunction

    function automatic void flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic void predict_lookup(input logic [DATA_W-1:0] addr);
        logic [DATA_W-1:0] divisor;
        logic [DATA_W-1:0] page_no;
        logic [DATA_W-1:0] oldest;
        int unsigned span;
        int unsigned slot;
        int unsigned k;
        bit found;
        bit empty_seen;
        lookup_t r;
        divisor = (page_size_now == 0) ? 1 : page_size_now;
        page_no = addr / divisor;
        span = active_span();
        found = 1'b0;
        empty_seen = 1'b0;
        slot = 0;
        r = '0;
        for (k = 0; k < span; k++)
            if (!found && frame_held[k] && page_of_frame[k] == page_no)
            begin
                found = 1'b1;
                slot = k;
            end
        if (!found)
        begin
            faults_now++;
            for (k = 0; k < span; k++)
                if (!empty_seen && !frame_held[k])
                begin
                    empty_seen = 1'b1;
                    slot = k;
                end
            if (!empty_seen)
            begin
                // least recently used, lowest index on ties
                oldest = stamp_of_frame[0];
                slot = 0;
                for (k = 1; k < span; k++)
                    if (stamp_of_frame[k] < oldest)
                    begin
                        oldest = stamp_of_frame[k];
                        slot = k;
                    end
                r.evicted_valid = 1'b1;
                r.evicted_page = page_of_frame[slot];
                eviction_tally++;
            end
            page_of_frame[slot] = page_no;
            frame_held[slot] = 1'b1;
        end
        else
            hit_tally++;
        stamp_of_frame[slot] = access_clock_now;
        access_clock_now++;
        references_now++;
        r.hit = found;
        r.frame = FRAME_W'(slot);
        r.fault_total = faults_now;
        r.reference_total = references_now;
        expected_lookups.push_back(r);
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Driver: one address beat at a time, random gaps between beats
    always @(posedge clk or negedge rst_n)
    begin : drive_addresses
        bit busy;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            address <= '0;
            send_gap = 0;
        end
        else
        begin
            busy = in_valid;
            if (in_valid && !in_stall)
            begin
                predict_lookup(address);
                busy = 1'b0;
                send_gap = pause_length();
            end
            if (!busy)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (address_backlog.size() > 0)
                begin
                    in_valid <= 1'b1;
                    address <= address_backlog.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random stall, check each accepted result beat
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        lookup_t want;
        lookup_t got;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                got = '{hit, frame, evicted_valid, evicted_page, fault_total,
                        reference_total};
                if (expected_lookups.size() == 0)
                    flag_error({"unexpected result ", show_lookup(got)});
                else
                begin
                    want = expected_lookups.pop_front();
                    if (got.hit !== want.hit || got.frame !== want.frame
                        || got.evicted_valid !== want.evicted_valid
                        || got.evicted_page !== want.evicted_page
                        || got.fault_total !== want.fault_total
                        || got.reference_total !== want.reference_total)
                        flag_error({"expected ", show_lookup(want),
                                    " actual ", show_lookup(got)});
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pause_length();
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("[%0t] no progress for %0d cycles", $realtime, IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PAGE_SIZE:     page_size_now = value;
            CFG_FRAMES_IN_USE: frames_now = value[FIU_W-1:0];
        endcase
    endtask

    task automatic queue_access(input logic [DATA_W-1:0] addr);
        address_backlog.push_back(addr);
        accesses_loaded++;
    endtask

    // Hold until every loaded access has produced its result
    task automatic drain();
        do
            @(posedge clk);
        while (results_seen < accesses_loaded);
    endtask

    // Program a setting, then run a working-set trace with some noise
    task automatic run_setting(input logic [DATA_W-1:0] ps, input logic [DATA_W-1:0] fiu,
                               input int unsigned count, input bit calm);
        logic [DATA_W-1:0] pool [$];
        logic [DATA_W-1:0] top_page;
        logic [DATA_W-1:0] divisor;
        logic [63:0] span64;
        logic [63:0] pg;
        logic [63:0] addr64;
        int unsigned pool_size;
        int unsigned k;
        write_register(CFG_PAGE_SIZE, ps);
        write_register(CFG_FRAMES_IN_USE, fiu);
        divisor = (page_size_now == 0) ? 1 : page_size_now;
        top_page = 32'hFFFF_FFFF / divisor;
        span64 = {32'd0, top_page} + 64'd1;
        pool_size = $urandom_range(1, active_span() + 4);
        for (k = 0; k < pool_size; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                pg = {32'd0, $urandom} % span64;
            else
                pg = $urandom_range(0, (top_page < 63) ? top_page : 63);
            pool.push_back(pg[DATA_W-1:0]);
        end
        quiet = calm;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < 10)
                queue_access($urandom);
            else
            begin
                pg = {32'd0, pool[$urandom_range(0, pool.size() - 1)]};
                addr64 = pg * divisor + ($urandom % divisor);
                if (addr64 > 64'hFFFF_FFFF)
                    addr64 = pg * divisor;
                queue_access(addr64[DATA_W-1:0]);
            end
        end
        drain();
        quiet = 1'b0;
        settings_run++;
    endtask

    initial
    begin : stimulus
        logic [DATA_W-1:0] ps_pick;
        logic [DATA_W-1:0] fiu_pick;
        int unsigned k;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setting: wrap-around addresses, a hit, fill every frame, evict
        queue_access(32'h0000_0000);
        queue_access(32'hFFFF_FFFF);
        queue_access(32'h0000_0FFF);
        for (k = 2; k < 16; k++)
            queue_access(k * 32'h1000 + k);
        queue_access(32'h5000_0000);
        queue_access(32'hFFFF_FFFF);
        drain();
        settings_run++;

        // Zero page size acts as one, zero frames acts as one frame
        write_register(CFG_PAGE_SIZE, 32'd0);
        write_register(CFG_FRAMES_IN_USE, 32'd0);
        queue_access(32'hFFFF_FFFF);
        queue_access(32'hFFFF_FFFF);
        queue_access(32'h0000_0000);
        drain();
        settings_run++;

        // Upper data bits dropped: three frames, older contents reused
        write_register(CFG_FRAMES_IN_USE, 32'hFFFF_FFE3);
        queue_access(32'h0000_0002);
        queue_access(32'h0005_0000);
        queue_access(32'h0000_0040);
        drain();
        settings_run++;

        run_setting(32'd4096, 32'd16, 100, 1'b1);
        run_setting(32'd1, 32'd1, 80, 1'b0);
        run_setting(32'hFFFF_FFFF, 32'd16, 80, 1'b0);
        run_setting(32'd64, 32'd4, 100, 1'b0);
        run_setting(32'd0, 32'd31, 100, 1'b0);
        run_setting(32'd3, 32'd17, 100, 1'b0);
        for (k = 0; k < 6; k++)
        begin
            case ($urandom_range(0, 5))
                0:       ps_pick = 32'd1 << $urandom_range(0, 31);
                1:       ps_pick = $urandom_range(1, 65536);
                2:       ps_pick = $urandom;
                3:       ps_pick = 32'd0;
                4:       ps_pick = 32'hFFFF_FFFF;
                default: ps_pick = $urandom_range(2, 100);
            endcase
            fiu_pick = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 16);
            run_setting(ps_pick, fiu_pick, $urandom_range(100, 130), k == 2);
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Ran %0d accesses under %0d register settings", accesses_loaded,
                 settings_run);
        $display("Saw %0d hits and %0d evictions; %0d mismatches, %0d results outstanding",
                 hit_tally, eviction_tally, mismatch_count, expected_lookups.size());
        if (mismatch_count == 0 && expected_lookups.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/lru_pr_pkg.sv
src/lru_pr_ram.sv
src/lru_pr_div.sv
src/lru_page_replacement_core.sv
tb/sv/tb_top.sv
